### rtl/ctt_pkg.sv
package ctt_pkg;

    typedef enum logic [1:0] {
        MODE_SEEK    = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_QUOTED  = 2'd2,
        MODE_WORD    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_NONE = 2'd2
    } kind_t;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [7:0] SEPARATOR_RESET = 8'd58;

    typedef struct packed {
        logic       emit;
        kind_t      kind;
        logic [7:0] token_char;
        mode_t      mode;
    } scan_result_t;

endpackage

### rtl/ctt_channels.sv
interface ctt_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

interface ctt_token_if;
    logic       valid;
    logic       ready;
    logic [1:0] item_kind;
    logic [7:0] token_char;

    modport source (output valid, output item_kind, output token_char, input ready);
    modport sink (input valid, input item_kind, input token_char, output ready);
endinterface

### rtl/ctt_scan.sv
module ctt_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          text_byte,
    input  logic [7:0]          separator_char,
    output ctt_pkg::scan_result_t result
);

    ctt_pkg::mode_t mode_reg;
    ctt_pkg::mode_t mode_next;
    logic           is_delim;

    assign is_delim = (text_byte == separator_char) || (text_byte == ctt_pkg::CHAR_SPACE) ||
                      (text_byte == ctt_pkg::CHAR_TAB) || (text_byte == ctt_pkg::CHAR_CR) ||
                      (text_byte == ctt_pkg::CHAR_LF);

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (text_byte == ctt_pkg::CHAR_NUL)
        begin
            mode_next = ctt_pkg::MODE_SEEK;
        end
        else
        begin
            case (mode_reg)
                ctt_pkg::MODE_SEEK:
                begin
                    if (is_delim)
                        mode_next = ctt_pkg::MODE_SEEK;
                    else if (text_byte == ctt_pkg::CHAR_HASH)
                        mode_next = ctt_pkg::MODE_COMMENT;
                    else if (text_byte == ctt_pkg::CHAR_QUOTE)
                        mode_next = ctt_pkg::MODE_QUOTED;
                    else
                        mode_next = ctt_pkg::MODE_WORD;
                end
                ctt_pkg::MODE_COMMENT:
                begin
                    if (text_byte == ctt_pkg::CHAR_LF)
                        mode_next = ctt_pkg::MODE_SEEK;
                end
                ctt_pkg::MODE_QUOTED:
                begin
                    if (text_byte == ctt_pkg::CHAR_QUOTE)
                        mode_next = ctt_pkg::MODE_SEEK;
                end
                ctt_pkg::MODE_WORD:
                begin
                    if (is_delim)
                        mode_next = ctt_pkg::MODE_SEEK;
                end
                default:
                begin
                    mode_next = ctt_pkg::MODE_SEEK;
                end
            endcase
        end
    end

    // result for the byte in the input register
    always_comb
    begin
        result.emit       = 1'b0;
        result.kind       = ctt_pkg::KIND_BYTE;
        result.token_char = '0;
        result.mode       = mode_reg;
        if (text_byte == ctt_pkg::CHAR_NUL)
        begin
            result.emit = 1'b1;
            if (mode_reg == ctt_pkg::MODE_WORD || mode_reg == ctt_pkg::MODE_QUOTED)
                result.kind = ctt_pkg::KIND_END;
            else
                result.kind = ctt_pkg::KIND_NONE;
        end
        else
        begin
            case (mode_reg)
                ctt_pkg::MODE_SEEK:
                begin
                    if (!is_delim && text_byte != ctt_pkg::CHAR_HASH &&
                        text_byte != ctt_pkg::CHAR_QUOTE)
                    begin
                        result.emit       = 1'b1;
                        result.token_char = text_byte;
                    end
                end
                ctt_pkg::MODE_COMMENT:
                begin
                    result.emit = 1'b0;
                end
                ctt_pkg::MODE_QUOTED:
                begin
                    result.emit = 1'b1;
                    if (text_byte == ctt_pkg::CHAR_QUOTE)
                        result.kind = ctt_pkg::KIND_END;
                    else
                        result.token_char = text_byte;
                end
                ctt_pkg::MODE_WORD:
                begin
                    result.emit = 1'b1;
                    if (is_delim)
                        result.kind = ctt_pkg::KIND_END;
                    else
                        result.token_char = text_byte;
                end
                default:
                begin
                    result.emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= ctt_pkg::MODE_SEEK;
        else if (step)
            mode_reg <= mode_next;
    end

endmodule

### rtl/config_text_tokenizer_unit.sv
// A word's result passes from the input register to the output register as it advances;
// one word per cycle when not stalled; mode update is a single compare-and-select level.
// A word that gives no result (delimiter, comment byte, opening quote) does not wait.
// Reset: scan mode returns to seeking, separator reads 58, input and output stages empty.
module config_text_tokenizer_unit (
    input  logic        clk,
    input  logic        rst_n,
    ctt_text_if.sink    text,
    ctt_token_if.source tokens,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    logic       cfg_write;
    logic [7:0] separator_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic [1:0] out_kind_reg;
    logic [7:0] out_char_reg;
    logic       advance;

    ctt_pkg::scan_result_t scan;

    assign cfg_write = cfg_we;

    ctt_scan u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .text_byte      (in_byte_reg),
        .separator_char (separator_reg),
        .result         (scan)
    );

    // a word with no result never waits on the output side
    assign advance    = in_valid_reg && (!scan.emit || !out_valid_reg || tokens.ready);
    assign text.ready = !in_valid_reg || advance;

    assign tokens.valid      = out_valid_reg;
    assign tokens.item_kind  = out_kind_reg;
    assign tokens.token_char = out_char_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            separator_reg <= ctt_pkg::SEPARATOR_RESET;
        else if (cfg_write)
            separator_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (text.ready)
            in_valid_reg <= text.valid;
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
            in_byte_reg <= text.text_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && scan.emit)
            out_valid_reg <= 1'b1;
        else if (tokens.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && scan.emit)
        begin
            out_kind_reg <= scan.kind;
            out_char_reg <= scan.token_char;
        end
    end

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !tokens.ready && in_valid_reg && scan.emit) |-> !advance)
        else $error("result register overwritten while stalled");

    a_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        (text.valid && text.ready && in_valid_reg) |-> advance)
        else $error("input register overwritten before its word was processed");

    a_marker_char: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && tokens.item_kind != ctt_pkg::KIND_BYTE) |-> tokens.token_char == '0)
        else $error("marker result carries a nonzero byte");

    a_nul_seek: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_byte_reg == ctt_pkg::CHAR_NUL) |=> scan.mode == ctt_pkg::MODE_SEEK)
        else $error("end of text did not return to seeking");
`endif

endmodule

### sim/tb_config_text_tokenizer_unit.sv
module tb_config_text_tokenizer_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int HOLD_CYCLES    = 250;
    localparam int PHASE_BYTES    = 70;
    localparam int NUM_PHASES     = 8;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct {
        ctt_pkg::kind_t kind;
        logic [7:0]     ch;
    } token_t;

    class token_scoreboard;
        logic [7:0]     separator;
        ctt_pkg::mode_t mode;
        token_t         token_q[$];
        int             errors;

        function new();
            separator = ctt_pkg::SEPARATOR_RESET;
            mode      = ctt_pkg::MODE_SEEK;
            errors    = 0;
        endfunction

        function bit is_gap(logic [7:0] b);
            return b == separator || b == ctt_pkg::CHAR_SPACE || b == ctt_pkg::CHAR_TAB ||
                   b == ctt_pkg::CHAR_CR || b == ctt_pkg::CHAR_LF;
        endfunction

        function int pending();
            return token_q.size();
        endfunction

        function void push(ctt_pkg::kind_t k, logic [7:0] c);
            token_t t;
            t.kind = k;
            t.ch   = c;
            token_q.push_back(t);
        endfunction

        // one accepted text word -> zero or one expected token word
        function void note_text(logic [7:0] b);
            ctt_pkg::mode_t cur;
            cur = mode;
            if (b == ctt_pkg::CHAR_NUL)
            begin
                mode = ctt_pkg::MODE_SEEK;
                if (cur == ctt_pkg::MODE_WORD || cur == ctt_pkg::MODE_QUOTED)
                    push(ctt_pkg::KIND_END, 8'h00);
                else
                    push(ctt_pkg::KIND_NONE, 8'h00);
                return;
            end
            case (cur)
                ctt_pkg::MODE_SEEK:
                begin
                    // separator wins over hash and quote
                    if (is_gap(b))
                        ;
                    else if (b == ctt_pkg::CHAR_HASH)
                        mode = ctt_pkg::MODE_COMMENT;
                    else if (b == ctt_pkg::CHAR_QUOTE)
                        mode = ctt_pkg::MODE_QUOTED;
                    else
                    begin
                        mode = ctt_pkg::MODE_WORD;
                        push(ctt_pkg::KIND_BYTE, b);
                    end
                end
                ctt_pkg::MODE_COMMENT:
                begin
                    if (b == ctt_pkg::CHAR_LF)
                        mode = ctt_pkg::MODE_SEEK;
                end
                ctt_pkg::MODE_QUOTED:
                begin
                    if (b == ctt_pkg::CHAR_QUOTE)
                    begin
                        mode = ctt_pkg::MODE_SEEK;
                        push(ctt_pkg::KIND_END, 8'h00);
                    end
                    else
                        push(ctt_pkg::KIND_BYTE, b);
                end
                default:
                begin
                    if (is_gap(b))
                    begin
                        mode = ctt_pkg::MODE_SEEK;
                        push(ctt_pkg::KIND_END, 8'h00);
                    end
                    else
                        push(ctt_pkg::KIND_BYTE, b);
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_token(logic [1:0] kind, logic [7:0] ch);
            token_t want;
            if (token_q.size() == 0)
            begin
                report($sformatf("token word with nothing pending kind=%0d char=%02h",
                                 kind, ch));
                return;
            end
            want = token_q.pop_front();
            if (kind !== want.kind)
                report($sformatf("item_kind got %0d want %0d", kind, want.kind));
            if (ch !== want.ch)
                report($sformatf("token_char got %02h want %02h", ch, want.ch));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    bit         calm;
    bit         hold_req;
    int         cycle_count;
    logic [7:0] text_q[$];

    token_scoreboard sb = new();

    ctt_text_if  text_ch();
    ctt_token_if tok_ch();

    config_text_tokenizer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text_ch),
        .tokens    (tok_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[%0t] timeout", $realtime);
        $display("config_text_tokenizer_unit regression: fail");
        $finish;
    end

    // sink side: random stall bursts, one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        tok_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                tok_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (calm)
                tok_ch.ready = 1'b1;
            else if (stall_left > 0)
            begin
                tok_ch.ready = 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                tok_ch.ready = 1'b0;
                stall_left = $urandom_range(1, 11) - 1;
            end
            else
                tok_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && tok_ch.valid && tok_ch.ready)
            sb.check_token(tok_ch.item_kind, tok_ch.token_char);
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            text_ch.valid = 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(negedge clk);
        end
        text_ch.valid     = 1'b1;
        text_ch.text_byte = b;
        @(posedge clk);
        while (!text_ch.ready) @(posedge clk);
        sb.note_text(b);
        @(negedge clk);
    endtask

    task automatic send_queue();
        while (text_q.size() > 0)
            send_byte(text_q.pop_front());
        text_ch.valid = 1'b0;
    endtask

    task automatic write_separator(input logic [7:0] v);
        while (sb.pending() != 0) @(posedge clk);
        // words without a result may still be in flight
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.separator = v;
    endtask

    function automatic logic [7:0] word_byte(bit first);
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (sb.is_gap(b) ||
               (first && (b == ctt_pkg::CHAR_HASH || b == ctt_pkg::CHAR_QUOTE)));
        return b;
    endfunction

    function automatic logic [7:0] gap_byte();
        case ($urandom_range(0, 4))
            0: return (sb.separator == ctt_pkg::CHAR_NUL) ? ctt_pkg::CHAR_SPACE : sb.separator;
            1: return ctt_pkg::CHAR_SPACE;
            2: return ctt_pkg::CHAR_TAB;
            3: return ctt_pkg::CHAR_CR;
            default: return ctt_pkg::CHAR_LF;
        endcase
    endfunction

    function automatic logic [7:0] quoted_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == ctt_pkg::CHAR_QUOTE);
        return b;
    endfunction

    function automatic logic [7:0] comment_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == ctt_pkg::CHAR_LF);
        return b;
    endfunction

    // one text: a few tokens, comments and some noise, closed by a zero word
    task automatic add_text();
        int n_tok;
        int len;
        n_tok = $urandom_range(1, 6);
        repeat (n_tok)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    len = $urandom_range(1, 8);
                    text_q.push_back(word_byte(1'b1));
                    repeat (len - 1) text_q.push_back(word_byte(1'b0));
                end
                4, 5:
                begin
                    len = $urandom_range(0, 6);
                    text_q.push_back(ctt_pkg::CHAR_QUOTE);
                    repeat (len) text_q.push_back(quoted_byte());
                    text_q.push_back(ctt_pkg::CHAR_QUOTE);
                end
                6:
                begin
                    len = $urandom_range(0, 6);
                    text_q.push_back(ctt_pkg::CHAR_HASH);
                    repeat (len) text_q.push_back(comment_byte());
                    text_q.push_back(ctt_pkg::CHAR_LF);
                end
                7:
                    text_q.push_back(8'($urandom_range(0, 255)));
                8:
                begin
                    len = $urandom_range(1, 3);
                    repeat (len) text_q.push_back(gap_byte());
                end
                default:
                begin
                    len = $urandom_range(1, 3);
                    repeat (len) text_q.push_back(8'($urandom_range(1, 255)));
                end
            endcase
            len = $urandom_range(1, 2);
            repeat (len) text_q.push_back(gap_byte());
        end
        // end of text lands in each mode now and then
        case ($urandom_range(0, 4))
            0: text_q.push_back(word_byte(1'b1));
            1:
            begin
                text_q.push_back(ctt_pkg::CHAR_QUOTE);
                len = $urandom_range(0, 3);
                repeat (len) text_q.push_back(quoted_byte());
            end
            2: text_q.push_back(ctt_pkg::CHAR_HASH);
            default: ;
        endcase
        text_q.push_back(ctt_pkg::CHAR_NUL);
    endtask

    initial
    begin
        logic [7:0] sep;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 8'h00;
        calm              = 1'b0;
        hold_req          = 1'b0;
        text_ch.valid     = 1'b0;
        text_ch.text_byte = 8'h00;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, separator at its reset value
        text_q = '{8'h61, 8'hFF, 8'h3A,
                   ctt_pkg::CHAR_SPACE, ctt_pkg::CHAR_TAB, ctt_pkg::CHAR_CR, ctt_pkg::CHAR_LF,
                   ctt_pkg::CHAR_HASH, ctt_pkg::CHAR_QUOTE, ctt_pkg::CHAR_LF,
                   ctt_pkg::CHAR_QUOTE, ctt_pkg::CHAR_HASH, ctt_pkg::CHAR_SPACE,
                   ctt_pkg::CHAR_QUOTE,
                   ctt_pkg::CHAR_QUOTE, ctt_pkg::CHAR_QUOTE,
                   8'h80, ctt_pkg::CHAR_HASH, ctt_pkg::CHAR_QUOTE, ctt_pkg::CHAR_NUL,
                   ctt_pkg::CHAR_NUL,
                   ctt_pkg::CHAR_HASH, ctt_pkg::CHAR_NUL,
                   ctt_pkg::CHAR_QUOTE, ctt_pkg::CHAR_NUL};
        send_queue();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: sep = 8'h00;
                1: sep = 8'hFF;
                2: sep = ctt_pkg::CHAR_HASH;
                3: sep = ctt_pkg::CHAR_QUOTE;
                4: sep = ctt_pkg::CHAR_SPACE;
                7: sep = ctt_pkg::SEPARATOR_RESET;
                default: sep = 8'($urandom_range(1, 255));
            endcase
            write_separator(sep);
            if (phase == 1)
                hold_req = 1'b1;
            if (phase == NUM_PHASES - 1)
                calm = 1'b1;
            while (text_q.size() < PHASE_BYTES)
                add_text();
            send_queue();
        end

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("config_text_tokenizer_unit regression: pass");
        else
            $display("config_text_tokenizer_unit regression: fail");
        $finish;
    end

endmodule

### config_text_tokenizer_unit.f
rtl/ctt_pkg.sv
rtl/ctt_channels.sv
rtl/ctt_scan.sv
rtl/config_text_tokenizer_unit.sv
sim/tb_config_text_tokenizer_unit.sv
